// ----- hw/rtl/stsr_pkg.sv -----
`default_nettype none

package stsr_pkg;

  typedef enum logic [2:0] {
    MODE_WIGGLE       = 3'd0,
    MODE_POS_FILL     = 3'd1,
    MODE_NEG_FILL     = 3'd2,
    MODE_DENSITY_SPAN = 3'd3,
    MODE_DENSITY_DOT  = 3'd4
  } plot_mode_t;

  typedef enum logic [2:0] {
    CFG_PLOT_MODE    = 3'd0,
    CFG_BASE_COLUMN  = 3'd1,
    CFG_START_ROW    = 3'd2,
    CFG_IMAGE_WIDTH  = 3'd3,
    CFG_IMAGE_HEIGHT = 3'd4,
    CFG_FILL_COLOR   = 3'd5
  } cfg_index_t;

  localparam logic signed [13:0] ROW_LIMIT = 14'sd8191;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] start;
    logic [11:0] stop;
    logic [7:0]  color;
  } span_t;

  typedef struct packed {
    logic  valid;
    span_t span;
  } cand_t;

endpackage

`default_nettype wire

// ----- hw/rtl/seismic_trace_span_rasterizer.sv -----
// Seismic trace span rasterizer.
// Input channel (in_valid/in_ready): one trace sample per item, amplitude as a
// signed column offset from the base column, a density colour and a flag on
// the last sample of the trace. Output channel (out_valid/out_ready): raster
// spans (row, first and last column inclusive, colour), out_span_last set on
// the final span a sample produces. A sample gives zero, one or two spans.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index; write
// only while no item is in flight.
// An accepted item passes the input register and then the output register.
// Throughput: one sample per cycle while out_ready is high and the sample
// gives at most one span; a wiggle pair uses the single span output in turn.
// The second span of a pair waits in a one-entry queue behind the output
// register. While the receiver stalls, the input register takes one more
// item and then in_ready drops; all spans hold until taken.
// Reset (synchronous, rst_n low): configuration registers return to their
// defaults, the pipeline empties and the next sample starts a new trace.
`default_nettype none

module seismic_trace_span_rasterizer #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [12:0] in_amplitude,
  input  logic [7:0]  in_density,
  input  logic        in_last_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_span_row,
  output logic [11:0] out_span_start,
  output logic [11:0] out_span_end,
  output logic [7:0]  out_span_color,
  output logic        out_span_last,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);

  stsr_pkg::plot_mode_t plot_mode_r;
  logic signed [12:0]   base_column_r;
  logic signed [12:0]   start_row_r;
  logic [12:0]          image_width_r;
  logic [12:0]          image_height_r;
  logic [7:0]           fill_color_r;
  logic [12:0]          eff_width;
  logic [12:0]          eff_height;

  logic signed [12:0]   prev_offset_r;
  logic signed [13:0]   row_pos_r;
  logic                 have_prev_r;
  logic signed [13:0]   row_in;

  logic                 s1_valid_r;
  logic signed [12:0]   s1_amp_r;
  logic [7:0]           s1_dens_r;
  logic signed [12:0]   s1_prev_r;
  logic                 s1_have_prev_r;
  logic signed [13:0]   s1_row_r;

  stsr_pkg::cand_t      cand0;
  stsr_pkg::cand_t      cand1;

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  stsr_pkg::span_t      out_span_r;
  stsr_pkg::span_t      out_span_nxt;
  logic                 out_last_r;
  logic                 out_last_nxt;
  logic                 q_valid_r;
  logic                 q_valid_nxt;
  stsr_pkg::span_t      q_span_r;
  stsr_pkg::span_t      q_span_nxt;

  logic                 in_fire;
  logic                 load_ok;
  logic                 s1_adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plot_mode_r    <= stsr_pkg::MODE_WIGGLE;
      base_column_r  <= '0;
      start_row_r    <= '0;
      image_width_r  <= 13'd4096;
      image_height_r <= 13'd4096;
      fill_color_r   <= 8'd255;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        stsr_pkg::CFG_PLOT_MODE:    plot_mode_r    <= stsr_pkg::plot_mode_t'(cfg_wdata[2:0]);
        stsr_pkg::CFG_BASE_COLUMN:  base_column_r  <= cfg_wdata;
        stsr_pkg::CFG_START_ROW:    start_row_r    <= cfg_wdata;
        stsr_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        stsr_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
        stsr_pkg::CFG_FILL_COLOR:   fill_color_r   <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  assign eff_width  = ({19'd0, image_width_r} < 32'(MAX_WIDTH)) ?
                      image_width_r : 13'(MAX_WIDTH);
  assign eff_height = ({19'd0, image_height_r} < 32'(MAX_HEIGHT)) ?
                      image_height_r : 13'(MAX_HEIGHT);

  // handshake
  assign load_ok  = !out_valid_r || (out_ready && !q_valid_r);
  assign s1_adv   = s1_valid_r && load_ok;
  assign in_ready = !s1_valid_r || load_ok;
  assign in_fire  = in_valid && in_ready;

  // trace state advances on accept
  assign row_in = have_prev_r ? row_pos_r : {start_row_r[12], start_row_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_offset_r <= '0;
      row_pos_r     <= '0;
      have_prev_r   <= 1'b0;
    end else if (in_fire) begin
      prev_offset_r <= in_amplitude;
      row_pos_r     <= (row_in < stsr_pkg::ROW_LIMIT) ? row_in + 14'sd1 : stsr_pkg::ROW_LIMIT;
      have_prev_r   <= !in_last_sample;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_amp_r       <= in_amplitude;
      s1_dens_r      <= in_density;
      s1_prev_r      <= prev_offset_r;
      s1_have_prev_r <= have_prev_r;
      s1_row_r       <= row_in;
    end
  end

  stsr_span_calc u_calc (
    .mode        (plot_mode_r),
    .base_column (base_column_r),
    .fill_color  (fill_color_r),
    .eff_width   (eff_width),
    .eff_height  (eff_height),
    .have_prev   (s1_have_prev_r),
    .prev_offset (s1_prev_r),
    .amplitude   (s1_amp_r),
    .density     (s1_dens_r),
    .row         (s1_row_r),
    .cand0       (cand0),
    .cand1       (cand1)
  );

  // output register and one queued span
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_span_nxt  = out_span_r;
    out_last_nxt  = out_last_r;
    q_valid_nxt   = q_valid_r;
    q_span_nxt    = q_span_r;
    if (out_valid_r && out_ready) begin
      if (q_valid_r) begin
        out_span_nxt = q_span_r;
        out_last_nxt = 1'b1;
        q_valid_nxt  = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (s1_adv) begin
      if (cand0.valid) begin
        out_valid_nxt = 1'b1;
        out_span_nxt  = cand0.span;
        out_last_nxt  = !cand1.valid;
        q_valid_nxt   = cand1.valid;
        q_span_nxt    = cand1.span;
      end else if (cand1.valid) begin
        out_valid_nxt = 1'b1;
        out_span_nxt  = cand1.span;
        out_last_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      q_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      q_valid_r   <= q_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_span_r <= out_span_nxt;
    out_last_r <= out_last_nxt;
    q_span_r   <= q_span_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_span_row   = out_span_r.row;
  assign out_span_start = out_span_r.start;
  assign out_span_end   = out_span_r.stop;
  assign out_span_color = out_span_r.color;
  assign out_span_last  = out_last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/stsr_span_calc.sv -----
`default_nettype none

module stsr_span_calc (
  input  stsr_pkg::plot_mode_t mode,
  input  logic signed [12:0]   base_column,
  input  logic [7:0]           fill_color,
  input  logic [12:0]          eff_width,
  input  logic [12:0]          eff_height,
  input  logic                 have_prev,
  input  logic signed [12:0]   prev_offset,
  input  logic signed [12:0]   amplitude,
  input  logic [7:0]           density,
  input  logic signed [13:0]   row,
  output stsr_pkg::cand_t      cand0,
  output stsr_pkg::cand_t      cand1
);

  logic signed [15:0] b16;
  logic signed [15:0] x1;
  logic signed [15:0] x2;
  logic signed [15:0] prv_col;
  logic signed [15:0] amp_col;
  logic signed [15:0] diff_dn;
  logic signed [15:0] diff_up;
  logic signed [15:0] mid_dn;
  logic signed [15:0] mid_up;
  logic signed [14:0] row_cur;
  logic signed [14:0] row_prv;

  // clamp both ends into the width, drop rows outside the image and empty spans
  function automatic stsr_pkg::cand_t make_span(
    input logic signed [14:0] r,
    input logic signed [15:0] a,
    input logic signed [15:0] b,
    input logic [7:0]         color,
    input logic [12:0]        w,
    input logic [12:0]        h
  );
    stsr_pkg::cand_t    c;
    logic signed [15:0] wl;
    logic signed [15:0] ac;
    logic signed [15:0] bc;
    wl = $signed({3'b000, w}) - 16'sd1;
    ac = (a < 16'sd0) ? 16'sd0 : ((a > wl) ? wl : a);
    bc = (b < 16'sd0) ? 16'sd0 : ((b > wl) ? wl : b);
    c.valid = (w != 13'd0) && (r >= 15'sd0) && (r < $signed({2'b00, h})) && (ac <= bc);
    c.span.row   = r[11:0];
    c.span.start = ac[11:0];
    c.span.stop  = bc[11:0];
    c.span.color = color;
    return c;
  endfunction

  assign b16     = {{3{base_column[12]}}, base_column};
  assign x1      = {{3{prev_offset[12]}}, prev_offset};
  assign x2      = {{3{amplitude[12]}}, amplitude};
  assign prv_col = b16 + x1;
  assign amp_col = b16 + x2;
  assign diff_dn = x1 - x2;
  assign diff_up = x2 - x1;
  assign mid_dn  = prv_col - (diff_dn >>> 1);
  assign mid_up  = prv_col + (diff_up >>> 1);
  assign row_cur = {row[13], row};
  assign row_prv = row_cur - 15'sd1;

  always_comb begin
    cand0 = '0;
    cand1 = '0;
    case (mode)
      stsr_pkg::MODE_WIGGLE: begin
        if (have_prev) begin
          if (x1 == x2) begin
            cand0 = make_span(row_prv, prv_col, prv_col, fill_color, eff_width, eff_height);
            cand1 = make_span(row_cur, prv_col, prv_col, fill_color, eff_width, eff_height);
          end else if (x2 < x1) begin
            cand0 = make_span(row_prv, mid_dn, prv_col, fill_color, eff_width, eff_height);
            cand1 = make_span(row_cur, amp_col, mid_dn - 16'sd1, fill_color,
                              eff_width, eff_height);
          end else begin
            cand0 = make_span(row_prv, prv_col, mid_up, fill_color, eff_width, eff_height);
            cand1 = make_span(row_cur, mid_up + 16'sd1, amp_col, fill_color,
                              eff_width, eff_height);
          end
        end
      end
      stsr_pkg::MODE_POS_FILL: begin
        if (x2 >= 16'sd0) begin
          cand0 = make_span(row_cur, b16, amp_col, fill_color, eff_width, eff_height);
        end
      end
      stsr_pkg::MODE_NEG_FILL: begin
        if (x2 <= 16'sd0) begin
          cand0 = make_span(row_cur, amp_col, b16, fill_color, eff_width, eff_height);
        end
      end
      stsr_pkg::MODE_DENSITY_SPAN: begin
        if (x2 >= 16'sd0) begin
          cand0 = make_span(row_cur, b16, amp_col, density, eff_width, eff_height);
        end else begin
          cand0 = make_span(row_cur, amp_col, b16, density, eff_width, eff_height);
        end
      end
      stsr_pkg::MODE_DENSITY_DOT: begin
        cand0 = make_span(row_cur, b16, b16, density, eff_width, eff_height);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/stsr_checker.sv -----
`default_nettype none

module stsr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [11:0] out_span_row,
  input wire logic [11:0] out_span_start,
  input wire logic [11:0] out_span_end,
  input wire logic        out_span_last
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_span_row) &&
      $stable(out_span_start) && $stable(out_span_end))
    else $error("stalled span changed");

  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_span_start <= out_span_end)
    else $error("empty span emitted");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_span_last |=> out_valid && out_span_last)
    else $error("second span of a pair missing");

endmodule

bind seismic_trace_span_rasterizer stsr_checker u_stsr_checker (.*);

`default_nettype wire

// ----- test/tb_top.sv -----
module tb_top;

  localparam int MAX_WIDTH = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 10;
  localparam int IDLE_PERCENT = 18;
  localparam int RANDOM_PHASES = 20;
  localparam logic [2:0] MODE_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] MODE_RESERVED_LAST = 3'd7;

  typedef struct packed {
    stsr_pkg::span_t span;
    logic            last;
  } span_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [12:0] in_amplitude = '0;
  logic [7:0]  in_density = '0;
  logic        in_last_sample = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] out_span_row;
  logic [11:0] out_span_start;
  logic [11:0] out_span_end;
  logic [7:0]  out_span_color;
  logic        out_span_last;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_wdata = '0;

  seismic_trace_span_rasterizer #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_amplitude  (in_amplitude),
    .in_density    (in_density),
    .in_last_sample(in_last_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_span_row  (out_span_row),
    .out_span_start(out_span_start),
    .out_span_end  (out_span_end),
    .out_span_color(out_span_color),
    .out_span_last (out_span_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's registers and trace state
  logic [2:0] m_mode = stsr_pkg::MODE_WIGGLE;
  int m_base = 0;
  int m_start_row = 0;
  int m_width = 4096;
  int m_height = 4096;
  int m_fill = 255;
  int m_prev_amp = 0;
  int m_row = 0;
  bit m_in_trace = 1'b0;

  stsr_pkg::span_t new_spans[$];
  span_exp_t expected_spans[$];
  span_exp_t checker_want;

  bit no_idle = 1'b0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int samples_sent = 0;
  int spans_checked = 0;
  int setting_changes = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d spans outstanding", cycle_count,
               expected_spans.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < 20)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
               want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_spans.size() == 0) begin
        report_mismatch("span with none expected, row", out_span_row, -1);
      end else begin
        checker_want = expected_spans.pop_front();
        spans_checked++;
        if (out_span_row !== checker_want.span.row)
          report_mismatch("span_row", out_span_row, checker_want.span.row);
        if (out_span_start !== checker_want.span.start)
          report_mismatch("span_start", out_span_start, checker_want.span.start);
        if (out_span_end !== checker_want.span.stop)
          report_mismatch("span_end", out_span_end, checker_want.span.stop);
        if (out_span_color !== checker_want.span.color)
          report_mismatch("span_color", out_span_color, checker_want.span.color);
        if (out_span_last !== checker_want.last)
          report_mismatch("span_last", out_span_last, checker_want.last);
      end
    end
  end

  function automatic void add_span(int row, int a, int b, int color);
    int w;
    int h;
    stsr_pkg::span_t s;
    w = (m_width < MAX_WIDTH) ? m_width : MAX_WIDTH;
    h = (m_height < MAX_HEIGHT) ? m_height : MAX_HEIGHT;
    if (new_spans.size() >= 2 || w <= 0 || row < 0 || row >= h) return;
    if (a < 0) a = 0;
    if (a >= w) a = w - 1;
    if (b < 0) b = 0;
    if (b >= w) b = w - 1;
    if (a > b) return;
    s.row = row[11:0];
    s.start = a[11:0];
    s.stop = b[11:0];
    s.color = color[7:0];
    new_spans.push_back(s);
  endfunction

  task automatic predict_sample(int amp, int dens, logic last);
    int row;
    int base;
    int x1;
    int s1;
    int e1;
    span_exp_t rec;
    new_spans.delete();
    row = m_in_trace ? m_row : m_start_row;
    base = m_base;
    x1 = m_prev_amp;
    case (m_mode)
      stsr_pkg::MODE_WIGGLE: begin
        if (m_in_trace) begin
          if (x1 == amp) begin
            add_span(row - 1, base + x1, base + x1, m_fill);
            add_span(row, base + x1, base + x1, m_fill);
          end else if (amp < x1) begin
            e1 = base + x1;
            s1 = e1 - ((x1 - amp) >>> 1);
            add_span(row - 1, s1, e1, m_fill);
            add_span(row, base + amp, s1 - 1, m_fill);
          end else begin
            s1 = base + x1;
            e1 = s1 + ((amp - x1) >>> 1);
            add_span(row - 1, s1, e1, m_fill);
            add_span(row, e1 + 1, base + amp, m_fill);
          end
        end
      end
      stsr_pkg::MODE_POS_FILL: begin
        if (amp >= 0) add_span(row, base, base + amp, m_fill);
      end
      stsr_pkg::MODE_NEG_FILL: begin
        if (amp <= 0) add_span(row, base + amp, base, m_fill);
      end
      stsr_pkg::MODE_DENSITY_SPAN: begin
        if (amp >= 0) add_span(row, base, base + amp, dens);
        else add_span(row, base + amp, base, dens);
      end
      stsr_pkg::MODE_DENSITY_DOT: begin
        add_span(row, base, base, dens);
      end
      default: ;
    endcase
    foreach (new_spans[i]) begin
      rec.span = new_spans[i];
      rec.last = (i == new_spans.size() - 1);
      expected_spans.push_back(rec);
    end
    m_prev_amp = amp;
    m_row = (row < int'(stsr_pkg::ROW_LIMIT)) ? row + 1 : int'(stsr_pkg::ROW_LIMIT);
    m_in_trace = !last;
  endtask

  task automatic send_sample(logic signed [12:0] amp, logic [7:0] dens, logic last);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_amplitude <= amp;
    in_density <= dens;
    in_last_sample <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_sample(amp, dens, last);
    samples_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(stsr_pkg::cfg_index_t idx, logic [12:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [2:0] mode, int base, int srow, int width, int height,
                               int color);
    wait_drained();
    write_reg(stsr_pkg::CFG_PLOT_MODE, {10'd0, mode});
    write_reg(stsr_pkg::CFG_BASE_COLUMN, base[12:0]);
    write_reg(stsr_pkg::CFG_START_ROW, srow[12:0]);
    write_reg(stsr_pkg::CFG_IMAGE_WIDTH, width[12:0]);
    write_reg(stsr_pkg::CFG_IMAGE_HEIGHT, height[12:0]);
    write_reg(stsr_pkg::CFG_FILL_COLOR, {5'd0, color[7:0]});
    m_mode = mode;
    m_base = base;
    m_start_row = srow;
    m_width = width;
    m_height = height;
    m_fill = color;
    setting_changes++;
  endtask

  // wiggle with the reset settings: first sample, equal pair, rise, fall with clamping
  task automatic test_reset_wiggle();
    send_sample(13'sd0, 8'd0, 1'b0);
    send_sample(13'sd0, 8'd255, 1'b0);
    send_sample(13'sd4095, 8'd0, 1'b0);
    send_sample(-13'sd4096, 8'd255, 1'b0);
    send_sample(13'sd100, 8'd1, 1'b1);
  endtask

  // fill modes, sign filtering, mode change inside an open trace
  task automatic test_fill_modes();
    apply_setting(stsr_pkg::MODE_POS_FILL, 2000, 10, 4096, 4096, 0);
    send_sample(13'sd4095, 8'd0, 1'b0);
    send_sample(-13'sd1, 8'd0, 1'b0);
    send_sample(13'sd0, 8'd0, 1'b0);
    apply_setting(stsr_pkg::MODE_NEG_FILL, 4095, 10, 4096, 4096, 128);
    send_sample(-13'sd4096, 8'd0, 1'b0);
    send_sample(13'sd5, 8'd0, 1'b0);
    send_sample(13'sd0, 8'd0, 1'b1);
  endtask

  // density colours, rows at the bottom edge, a width of one and a height of three
  task automatic test_density_modes();
    apply_setting(stsr_pkg::MODE_DENSITY_SPAN, 100, 4094, 4096, 4096, 255);
    send_sample(-13'sd10, 8'd0, 1'b0);
    send_sample(13'sd10, 8'd255, 1'b0);
    send_sample(13'sd5, 8'd7, 1'b1);
    apply_setting(stsr_pkg::MODE_DENSITY_DOT, -4096, -2, 1, 3, 0);
    send_sample(13'sd4095, 8'd1, 1'b0);
    send_sample(-13'sd4096, 8'd2, 1'b0);
    send_sample(13'sd0, 8'd3, 1'b0);
    send_sample(13'sd1, 8'd4, 1'b0);
    send_sample(-13'sd1, 8'd5, 1'b0);
    send_sample(13'sd2, 8'd6, 1'b1);
  endtask

  // reserved mode keeps rows moving, then wiggle pairs with its sample
  task automatic test_reserved_mode();
    apply_setting(MODE_RESERVED_LAST, 4095, 0, 4096, 4096, 0);
    send_sample(13'sd50, 8'd9, 1'b0);
    send_sample(-13'sd50, 8'd9, 1'b0);
    apply_setting(stsr_pkg::MODE_WIGGLE, 4095, 0, 1, 4096, 9);
    send_sample(-13'sd4096, 8'd0, 1'b0);
    send_sample(13'sd4095, 8'd0, 1'b1);
  endtask

  function automatic int pick_extent();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return ($urandom_range(0, 1) != 0) ? 1 : 4096;
    if (r < 5) return $urandom_range(1, 64);
    return $urandom_range(1, 4096);
  endfunction

  task automatic test_random_traces();
    int phase;
    int n;
    int items;
    int trace_left;
    int width;
    int height;
    int base;
    int srow;
    int color;
    int amp;
    int r;
    logic [2:0] mode;
    trace_left = 0;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      no_idle = (phase == 1);
      items = (phase == 1) ? 200 : 70;
      mode = ($urandom_range(0, 99) < 8) ?
             3'($urandom_range(MODE_RESERVED_FIRST, MODE_RESERVED_LAST)) :
             3'($urandom_range(stsr_pkg::MODE_WIGGLE, stsr_pkg::MODE_DENSITY_DOT));
      width = pick_extent();
      height = pick_extent();
      case ($urandom_range(0, 3))
        0: base = ($urandom_range(0, 1) != 0) ? -4096 : 4095;
        1: base = $urandom_range(0, 8191) - 4096;
        default: base = $urandom_range(0, width);
      endcase
      case ($urandom_range(0, 5))
        0: srow = ($urandom_range(0, 1) != 0) ? -4096 : 4095;
        1: srow = $urandom_range(0, 8191) - 4096;
        default: srow = $urandom_range(0, height + 8) - 8;
      endcase
      // keep both inside the signed register range
      if (base > 4095) base = 4095;
      if (srow > 4095) srow = 4095;
      r = $urandom_range(0, 9);
      color = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(0, 255);
      apply_setting(mode, base, srow, width, height, color);
      for (n = 0; n < items; n++) begin
        if (trace_left == 0)
          trace_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) :
                       $urandom_range(4, 40);
        r = $urandom_range(0, 9);
        if (r < 4) amp = m_prev_amp + $urandom_range(0, 64) - 32;
        else if (r < 5) amp = ($urandom_range(0, 1) != 0) ? -4096 : 4095;
        else if (r < 6) amp = m_prev_amp;
        else if (r < 8) amp = $urandom_range(0, width + 16) - base - 8;
        else amp = $urandom_range(0, 8191) - 4096;
        if (amp > 4095) amp = 4095;
        if (amp < -4096) amp = -4096;
        send_sample(amp[12:0], 8'($urandom_range(0, 255)), trace_left == 1);
        trace_left--;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_wiggle();
    test_fill_modes();
    test_density_modes();
    test_reserved_mode();
    test_random_traces();
    wait_drained();
    $display("%0d samples sent, %0d spans checked, %0d register settings applied",
             samples_sent, spans_checked, setting_changes);
    $display("all plot modes, unused modes, clamped columns and dropped rows covered");
    if (mismatch_count == 0 && expected_spans.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule
